// File: rtl/pclb_pkg.sv
`default_nettype none

package pclb_pkg;

  localparam int REG_W  = 31;  // configuration register width
  localparam int NUM_W  = 35;  // doubled, offset coordinate (signed)
  localparam int MAG_W  = 33;  // magnitude of that numerator
  localparam int DIV_W  = 32;  // doubled cell size
  localparam int QUO_W  = 34;  // signed bin coordinate
  localparam int FLAT_W = 48;  // signed flat index, full range
  localparam int CFG_IDX_W = 3;

  localparam logic [REG_W-1:0] BOX_RESET  = 31'd0;
  localparam logic [REG_W-1:0] CELL_RESET = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X  = 3'd0,
    CFG_BOX_Y  = 3'd1,
    CFG_BOX_Z  = 3'd2,
    CFG_CELL_X = 3'd3,
    CFG_CELL_Y = 3'd4,
    CFG_CELL_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NEG    = 2'd1,
    ST_BEYOND = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_SUM,
    S_CHK,
    S_RMW,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic        frame_start;
    logic [15:0] particle_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [8:0] cell_index;
    logic [3:0] slot_index;
    status_e    status;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/pclb_stream_if.sv
`default_nettype none

interface pclb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/pclb_ram.sv
`default_nettype none

module pclb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/particle_cell_list_binner.sv
`default_nettype none

// Channel   Dir  Payload                                          Handshake
// in_i      in   frame_start, particle_id, pos_x, pos_y, pos_z     valid/ready
// out_o     out  cell_index, slot_index, status                   valid/ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                   write strobe
//
// One item is in work at a time; the shared one-bit-per-cycle divider handles x,
// y and z in turn. A count is read only when the flat index is in range. After
// reset, and after accepting an item with frame_start set, a clearing pass writes
// zero to all CELL_COUNT count entries, one per cycle. Results sit in an output
// register; the next item is taken while it waits, and that item's result holds
// in S_EMIT until it frees.

module particle_cell_list_binner #(
  parameter int GRID_X     = 8,
  parameter int GRID_Y     = 8,
  parameter int GRID_Z     = 8,
  parameter int CELL_COUNT = 512,
  parameter int BIN_DEPTH  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  pclb_stream_if.sink                        in_i,
  pclb_stream_if.source                      out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [pclb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pclb_pkg::REG_W-1:0]     cfg_data_i
);

  localparam int CW   = CELL_COUNT > 1 ? $clog2(CELL_COUNT) : 1;
  localparam int NW   = $clog2(BIN_DEPTH + 1);
  localparam int LD   = CELL_COUNT * BIN_DEPTH;
  localparam int LW   = LD > 1 ? $clog2(LD) : 1;
  localparam int DCW  = $clog2(pclb_pkg::MAG_W);
  localparam int GZ_UNUSED_CHECK = GRID_Z;  // z extent only bounds the flat index via CELL_COUNT
  localparam logic signed [pclb_pkg::FLAT_W-1:0] GX_C  = pclb_pkg::FLAT_W'(GRID_X);
  localparam logic signed [pclb_pkg::FLAT_W-1:0] GXY_C =
    pclb_pkg::FLAT_W'(GRID_X * GRID_Y);
  localparam logic signed [pclb_pkg::FLAT_W-1:0] LAST_CELL =
    pclb_pkg::FLAT_W'(CELL_COUNT - 1 + GZ_UNUSED_CHECK - GRID_Z);

  // configuration
  logic [pclb_pkg::REG_W-1:0] box_x_q, box_y_q, box_z_q;
  logic [pclb_pkg::REG_W-1:0] cell_x_q, cell_y_q, cell_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q  <= pclb_pkg::BOX_RESET;
      box_y_q  <= pclb_pkg::BOX_RESET;
      box_z_q  <= pclb_pkg::BOX_RESET;
      cell_x_q <= pclb_pkg::CELL_RESET;
      cell_y_q <= pclb_pkg::CELL_RESET;
      cell_z_q <= pclb_pkg::CELL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pclb_pkg::CFG_BOX_X:  box_x_q  <= cfg_data_i;
        pclb_pkg::CFG_BOX_Y:  box_y_q  <= cfg_data_i;
        pclb_pkg::CFG_BOX_Z:  box_z_q  <= cfg_data_i;
        pclb_pkg::CFG_CELL_X: cell_x_q <= cfg_data_i;
        pclb_pkg::CFG_CELL_Y: cell_y_q <= cfg_data_i;
        pclb_pkg::CFG_CELL_Z: cell_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control
  pclb_pkg::state_e state_q, state_d;
  pclb_pkg::axis_e  axis_q;
  logic             pend_q;
  logic [CW-1:0]    clr_cnt_q;
  logic [DCW-1:0]   div_cnt_q;
  logic             out_valid_q;

  // datapath
  pclb_pkg::in_item_t  item_q;
  pclb_pkg::out_item_t res_q, out_q;
  logic [pclb_pkg::DIV_W-1:0] rem_q, dvs_q;
  logic [pclb_pkg::MAG_W-1:0] quo_q;
  logic                       neg_q;
  logic signed [pclb_pkg::QUO_W-1:0]  qx_q, qy_q, qz_q;
  logic signed [pclb_pkg::FLAT_W-1:0] px_q, py_q, pz_q, flat_q;
  logic [NW-1:0] cnt_rd;

  // numerator and divisor for the current axis
  logic signed [pclb_pkg::NUM_W-1:0] num;
  logic [pclb_pkg::REG_W-1:0]        csz;
  logic [pclb_pkg::MAG_W-1:0]        num_mag;

  always_comb begin
    unique case (axis_q)
      pclb_pkg::AX_X: begin
        num = (pclb_pkg::NUM_W'(item_q.pos_x) <<< 1) +
              $signed({4'd0, box_x_q});
        csz = cell_x_q;
      end
      pclb_pkg::AX_Y: begin
        num = (pclb_pkg::NUM_W'(item_q.pos_y) <<< 1) +
              $signed({4'd0, box_y_q});
        csz = cell_y_q;
      end
      default: begin
        num = $signed({4'd0, box_z_q}) - (pclb_pkg::NUM_W'(item_q.pos_z) <<< 1) -
              pclb_pkg::NUM_W'(2);
        csz = cell_z_q;
      end
    endcase
    num_mag = num[pclb_pkg::NUM_W-1] ? pclb_pkg::MAG_W'(-num) : pclb_pkg::MAG_W'(num);
  end

  // one restoring step
  logic [pclb_pkg::DIV_W:0]   trial;
  logic [pclb_pkg::DIV_W:0]   diff;
  logic [pclb_pkg::DIV_W-1:0] rem_nx;
  logic [pclb_pkg::MAG_W-1:0] quo_nx;
  logic signed [pclb_pkg::QUO_W-1:0] q_fin;

  always_comb begin
    trial  = {rem_q, quo_q[pclb_pkg::MAG_W-1]};
    diff   = trial - {1'b0, dvs_q};
    if (!diff[pclb_pkg::DIV_W]) begin
      rem_nx = diff[pclb_pkg::DIV_W-1:0];
      quo_nx = {quo_q[pclb_pkg::MAG_W-2:0], 1'b1};
    end else begin
      rem_nx = trial[pclb_pkg::DIV_W-1:0];
      quo_nx = {quo_q[pclb_pkg::MAG_W-2:0], 1'b0};
    end
    q_fin = neg_q ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});
  end

  logic div_last, clr_last, emit_ok, flat_beyond, flat_neg, cnt_full;
  assign div_last    = div_cnt_q == DCW'(pclb_pkg::MAG_W - 1);
  assign clr_last    = clr_cnt_q == CW'(CELL_COUNT - 1);
  assign emit_ok     = !out_valid_q || out_o.ready;
  assign flat_beyond = flat_q > LAST_CELL;
  assign flat_neg    = flat_q < 0;
  assign cnt_full    = cnt_rd >= NW'(BIN_DEPTH);

  logic [CW-1:0] cell_addr;
  assign cell_addr = flat_q[CW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pclb_pkg::S_CLEAR: if (clr_last) state_d = pend_q ? pclb_pkg::S_LOAD : pclb_pkg::S_IDLE;
      pclb_pkg::S_IDLE: begin
        if (in_i.valid) begin
          state_d = in_i.data.frame_start ? pclb_pkg::S_CLEAR : pclb_pkg::S_LOAD;
        end
      end
      pclb_pkg::S_LOAD: state_d = pclb_pkg::S_DIV;
      pclb_pkg::S_DIV: begin
        if (div_last) begin
          state_d = (axis_q == pclb_pkg::AX_Z) ? pclb_pkg::S_MUL : pclb_pkg::S_LOAD;
        end
      end
      pclb_pkg::S_MUL: state_d = pclb_pkg::S_SUM;
      pclb_pkg::S_SUM: state_d = pclb_pkg::S_CHK;
      pclb_pkg::S_CHK: state_d = (flat_beyond || flat_neg) ? pclb_pkg::S_EMIT : pclb_pkg::S_RMW;
      pclb_pkg::S_RMW: state_d = pclb_pkg::S_EMIT;
      pclb_pkg::S_EMIT: if (emit_ok) state_d = pclb_pkg::S_IDLE;
      default: state_d = pclb_pkg::S_IDLE;
    endcase
  end

  // outputs of the controller
  logic          cnt_we, cnt_re, list_we;
  logic [CW-1:0] cnt_waddr;
  logic [NW-1:0] cnt_wdata;
  logic [LW-1:0] list_addr;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_re    = 1'b0;
    list_we   = 1'b0;
    cnt_waddr = cell_addr;
    cnt_wdata = cnt_rd + NW'(1);
    unique case (state_q)
      pclb_pkg::S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_cnt_q;
        cnt_wdata = '0;
      end
      pclb_pkg::S_CHK: cnt_re = !(flat_beyond || flat_neg);
      pclb_pkg::S_RMW: begin
        cnt_we  = !cnt_full;
        list_we = !cnt_full;
      end
      default: ;
    endcase
    list_addr = LW'(LW'(cell_addr) * LW'(BIN_DEPTH)) + LW'(cnt_rd);
  end

  assign in_i.ready  = state_q == pclb_pkg::S_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pclb_pkg::S_CLEAR;
      pend_q      <= 1'b0;
      clr_cnt_q   <= '0;
      axis_q      <= pclb_pkg::AX_X;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        pclb_pkg::S_CLEAR: clr_cnt_q <= clr_last ? '0 : clr_cnt_q + CW'(1);
        pclb_pkg::S_IDLE: begin
          pend_q <= 1'b1;
          axis_q <= pclb_pkg::AX_X;
        end
        pclb_pkg::S_LOAD: div_cnt_q <= '0;
        pclb_pkg::S_DIV: begin
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_last) begin
            unique case (axis_q)
              pclb_pkg::AX_X: axis_q <= pclb_pkg::AX_Y;
              pclb_pkg::AX_Y: axis_q <= pclb_pkg::AX_Z;
              default:        axis_q <= pclb_pkg::AX_X;
            endcase
          end
        end
        default: ;
      endcase
      if (state_q == pclb_pkg::S_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pclb_pkg::S_IDLE: if (in_i.valid) item_q <= in_i.data;
      pclb_pkg::S_LOAD: begin
        rem_q <= '0;
        quo_q <= num_mag;
        neg_q <= num[pclb_pkg::NUM_W-1];
        dvs_q <= {((csz == '0) ? pclb_pkg::REG_W'(1) : csz), 1'b0};
      end
      pclb_pkg::S_DIV: begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        if (div_last) begin
          unique case (axis_q)
            pclb_pkg::AX_X: qx_q <= q_fin;
            pclb_pkg::AX_Y: qy_q <= q_fin;
            default:        qz_q <= q_fin;
          endcase
        end
      end
      pclb_pkg::S_MUL: begin
        px_q <= pclb_pkg::FLAT_W'(qx_q);
        py_q <= pclb_pkg::FLAT_W'(qy_q) * GX_C;
        pz_q <= pclb_pkg::FLAT_W'(qz_q) * GXY_C;
      end
      pclb_pkg::S_SUM: flat_q <= px_q + py_q + pz_q;
      pclb_pkg::S_CHK: begin
        res_q.cell_index <= '0;
        res_q.slot_index <= '0;
        res_q.status     <= flat_beyond ? pclb_pkg::ST_BEYOND : pclb_pkg::ST_NEG;
      end
      pclb_pkg::S_RMW: begin
        if (cnt_full) begin
          res_q.cell_index <= '0;
          res_q.slot_index <= '0;
          res_q.status     <= pclb_pkg::ST_FULL;
        end else begin
          res_q.cell_index <= 9'(cell_addr);
          res_q.slot_index <= 4'(cnt_rd);
          res_q.status     <= pclb_pkg::ST_OK;
        end
      end
      pclb_pkg::S_EMIT: if (emit_ok) out_q <= res_q;
      default: ;
    endcase
  end

  pclb_ram #(
    .WIDTH (NW),
    .DEPTH (CELL_COUNT)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cell_addr),
    .rdata_o (cnt_rd)
  );

  // cell lists are write-only from the ports
  pclb_ram #(
    .WIDTH (16),
    .DEPTH (LD)
  ) u_lists (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_addr),
    .wdata_i (item_q.particle_id),
    .re_i    (1'b0),
    .raddr_i (list_addr),
    .rdata_o ()
  );

endmodule

`default_nettype wire
